/* rtl/efr_pkg.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver package
// Shared types, codes and constants for the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package efr_pkg;

    // Position fields are sized for the largest supported frame length.
    localparam int POS_W = 6;

    // Framing bytes and reset value of the timeout reload register.
    localparam logic [7:0] START_MARK   = 8'h7F;
    localparam logic [7:0] END_MARK     = 8'h80;
    localparam logic [7:0] RELOAD_RESET = 8'd25;

    // Input item codes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // One input item.
    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } efr_in_t;

    // One result item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [4:0] position;
        logic       last;
        logic       checksum_ok;
    } efr_out_t;

    // Write request from the front end into the decoded byte buffer.
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } efr_wr_t;

    // Descriptor of one completed frame waiting for playback.
    typedef struct packed {
        logic             bank;
        logic [POS_W-1:0] lastpos;
        logic             ok;
    } efr_desc_t;

    // Playback state machine.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SEND
    } efr_back_state_t;

endpackage

`default_nettype wire

/* rtl/efr_front.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver front end
// Accepts bytes and ticks, tracks framing and timeout, removes escapes on the
// fly, computes the LRC verdict and hands finished frames to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_front #(
    parameter int MAX_FRAME = 19
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [7:0]       cfg_wr_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire efr_pkg::efr_in_t in_item,
    input  wire logic             q_full,
    output logic                  q_push,
    output efr_pkg::efr_desc_t    q_desc,
    output efr_pkg::efr_wr_t      buf_wr
);

    localparam int PW = efr_pkg::POS_W;

    // Control state.
    logic [7:0]    reload_reg, reload_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [7:0]    timeout_reg, timeout_next;
    logic          receiving_reg, receiving_next;
    logic          bank_reg, bank_next;

    // Per-frame decoder state, initialized by the opening byte; the length is loaded at position five.
    logic          esc_reg, esc_next;
    logic          run_odd_reg, run_odd_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    sum_reg, sum_next;
    logic          ok_reg, ok_next;

    logic          accept;
    logic [7:0]    rx;
    logic [PW-1:0] cnt_inc;
    logic          lrc_hit;
    logic          lrc_match;
    logic [7:0]    tick_one;
    logic [7:0]    tick_two;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign rx        = in_item.rx_byte;
    assign cnt_inc   = cnt_reg + PW'(1);

    // The checksum position is len + 6, reached only after len has been seen.
    assign lrc_hit   = (pos_reg > PW'(5)) &&
                       ({3'b000, pos_reg} == ({1'b0, len_reg} + 9'd6));
    assign lrc_match = (sum_reg == rx);

    // Tick countdown, by two while a frame is open, saturating at zero.
    assign tick_one = (timeout_reg != 8'd0) ? timeout_reg - 8'd1 : timeout_reg;
    assign tick_two = (receiving_reg && tick_one != 8'd0) ? tick_one - 8'd1 : tick_one;

    // Next-state logic for one accepted item.
    always_comb begin
        reload_next    = cfg_wr_en ? cfg_wr_data : reload_reg;
        cnt_next       = cnt_reg;
        timeout_next   = timeout_reg;
        receiving_next = receiving_reg;
        bank_next      = bank_reg;
        esc_next       = esc_reg;
        run_odd_next   = run_odd_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        ok_next        = ok_reg;
        q_push         = 1'b0;
        q_desc         = '0;
        buf_wr         = '0;

        if (accept) begin
            if (in_item.op == efr_pkg::OP_TICK) begin
                timeout_next = tick_two;
                if (tick_two == 8'd0) begin
                    cnt_next       = '0;
                    receiving_next = 1'b0;
                end
            end else if (cnt_reg == '0 && rx != efr_pkg::START_MARK) begin
                // Bad start: drop whatever was collected.
                cnt_next       = '0;
                receiving_next = 1'b0;
            end else begin
                timeout_next   = reload_reg;
                receiving_next = 1'b1;
                if (cnt_inc == PW'(MAX_FRAME)) begin
                    // Overlong frame: drop it but keep receiving.
                    cnt_next = '0;
                end else if (cnt_reg == '0) begin
                    // Opening byte starts a fresh frame.
                    cnt_next     = cnt_inc;
                    esc_next     = 1'b0;
                    run_odd_next = 1'b1;
                    pos_next     = PW'(2);
                    sum_next     = 8'd0;
                    ok_next      = 1'b0;
                end else begin
                    cnt_next     = cnt_inc;
                    run_odd_next = (rx == efr_pkg::START_MARK) ? !run_odd_reg : 1'b0;
                    if (!esc_reg && rx == efr_pkg::START_MARK) begin
                        esc_next = 1'b1;
                    end else begin
                        // Store one decoded byte and update the LRC.
                        esc_next    = 1'b0;
                        buf_wr.en   = 1'b1;
                        buf_wr.bank = bank_reg;
                        buf_wr.pos  = pos_reg;
                        buf_wr.data = rx;
                        if (pos_reg == PW'(5)) begin
                            len_next = rx;
                        end
                        if (lrc_hit) begin
                            ok_next = lrc_match;
                        end
                        sum_next = sum_reg + rx;
                        pos_next = pos_reg + PW'(1);
                        // End mark after an even run of escapes closes the frame.
                        if (rx == efr_pkg::END_MARK && !run_odd_reg) begin
                            q_push         = 1'b1;
                            q_desc.bank    = bank_reg;
                            q_desc.lastpos = pos_reg;
                            q_desc.ok      = lrc_hit ? lrc_match : ok_reg;
                            bank_next      = !bank_reg;
                            cnt_next       = '0;
                            receiving_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg    <= efr_pkg::RELOAD_RESET;
            cnt_reg       <= '0;
            timeout_reg   <= 8'd0;
            receiving_reg <= 1'b0;
            bank_reg      <= 1'b0;
        end else begin
            reload_reg    <= reload_next;
            cnt_reg       <= cnt_next;
            timeout_reg   <= timeout_next;
            receiving_reg <= receiving_next;
            bank_reg      <= bank_next;
        end
    end

    // Decoder registers.
    always_ff @(posedge aclk) begin
        esc_reg     <= esc_next;
        run_odd_reg <= run_odd_next;
        pos_reg     <= pos_next;
        len_reg     <= len_next;
        sum_reg     <= sum_next;
        ok_reg      <= ok_next;
    end

endmodule

`default_nettype wire

/* rtl/efr_queue.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver frame queue
// Two-entry queue of finished frame descriptors between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire efr_pkg::efr_desc_t push_desc,
    input  wire logic               pop,
    output efr_pkg::efr_desc_t      head,
    output logic                    empty,
    output logic                    full
);

    efr_pkg::efr_desc_t ent_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;

    assign head  = ent_reg[rd_ptr_reg];
    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);

    // Pointer and count update.
    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

/* rtl/efr_back.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver back end
// Holds the two-bank decoded byte buffer and plays finished frames out, one
// result item per byte, with last flag and LRC verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_back #(
    parameter int MAX_FRAME = 19
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire efr_pkg::efr_wr_t   buf_wr,
    input  wire efr_pkg::efr_desc_t q_head,
    input  wire logic               q_empty,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output efr_pkg::efr_out_t       out_item
);

    localparam int PW    = efr_pkg::POS_W;
    localparam int DEPTH = 2 * MAX_FRAME;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];

    efr_pkg::efr_back_state_t state_reg, state_next;
    logic [PW-1:0]            pos_reg, pos_next;
    logic [7:0]               rd_data_reg;

    logic          rd_en;
    logic          is_last;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    // Bank one sits above bank zero.
    assign wr_addr = AW'(buf_wr.pos) + (buf_wr.bank ? AW'(MAX_FRAME) : AW'(0));
    assign rd_addr = AW'(pos_reg) + (q_head.bank ? AW'(MAX_FRAME) : AW'(0));
    assign is_last = (pos_reg == q_head.lastpos);

    // Decoded byte buffer.
    always_ff @(posedge aclk) begin
        if (buf_wr.en) begin
            mem[wr_addr] <= buf_wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        case (state_reg)
            efr_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    pos_next   = PW'(2);
                    state_next = efr_pkg::BK_READ;
                end
            end
            efr_pkg::BK_READ: begin
                state_next = efr_pkg::BK_SEND;
            end
            efr_pkg::BK_SEND: begin
                if (out_ready) begin
                    if (is_last) begin
                        state_next = efr_pkg::BK_IDLE;
                    end else begin
                        pos_next   = pos_reg + PW'(1);
                        state_next = efr_pkg::BK_READ;
                    end
                end
            end
            default: begin
                state_next = efr_pkg::BK_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        rd_en                = 1'b0;
        out_valid            = 1'b0;
        q_pop                = 1'b0;
        out_item.data_byte   = rd_data_reg;
        out_item.position    = pos_reg[4:0];
        out_item.last        = is_last;
        out_item.checksum_ok = is_last && q_head.ok;
        case (state_reg)
            efr_pkg::BK_IDLE: begin
                rd_en = 1'b0;
            end
            efr_pkg::BK_READ: begin
                rd_en = 1'b1;
            end
            efr_pkg::BK_SEND: begin
                out_valid = 1'b1;
                q_pop     = out_ready && is_last;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= efr_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
    end

endmodule

`default_nettype wire

/* rtl/escaped_frame_receiver.sv */
// After a closing byte is accepted, its frame descriptor is registered in the
// queue; the back end, once idle, takes a read state (buffer read registered)
// and a send state for each item of the frame. Throughput: one input item per
// cycle while a frame bank is free; the queue holds two finished frames.
// Reset: synchronous active-low aresetn clears framing, timeout, queue and
// playback state; the timeout reload register returns to 25.
// ----------------------------------------------------------------------------
// Escaped frame receiver
// Byte-stuffed frame receiver with additive LRC check: front end decoder,
// frame descriptor queue and playback back end.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_receiver #(
    parameter int MAX_FRAME = 19
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [7:0]        cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire efr_pkg::efr_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output efr_pkg::efr_out_t      m_data
);

    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    efr_pkg::efr_desc_t q_desc;
    efr_pkg::efr_desc_t q_head;
    efr_pkg::efr_wr_t   buf_wr;

    // Decoder and framing.
    efr_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_item     (s_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_desc      (q_desc),
        .buf_wr      (buf_wr)
    );

    // Finished frames waiting for playback.
    efr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (q_desc),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Buffer and playback.
    efr_back #(
        .MAX_FRAME (MAX_FRAME)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .buf_wr    (buf_wr),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_data)
    );

endmodule

`default_nettype wire

/* rtl/efr_checker.sv */
// ----------------------------------------------------------------------------
// Escaped frame receiver checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire efr_pkg::efr_out_t m_data
);

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // Decoded positions start at two.
    a_pos_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.position >= 5'd2)
        else $error("result position below two");

    // Only the final byte of a frame may carry a passing checksum.
    a_ok_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !m_data.checksum_ok)
        else $error("checksum verdict on a non-final byte");

    // Within a frame, the next item follows a read state with no item, one position on.
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=> !m_valid ##1
        (m_valid && m_data.position == 5'($past(m_data.position, 2) + 5'd1)))
        else $error("frame items out of sequence");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escaped frame receiver testbench
// Drives received bytes and timer ticks through the input channel, decodes the
// same stream in a local frame decoder, and checks every decoded byte item
// against it. Runs through several timeout reload settings and idling mixes.
// ----------------------------------------------------------------------------

module testbench;

    localparam int FRAME_MAX = 19;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_wr_en;
    logic [7:0]        cfg_wr_data;
    logic              s_valid = 1'b0;
    logic              s_ready;
    efr_pkg::efr_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    efr_pkg::efr_out_t m_data;

    // Line items waiting to be sent and decoded bytes still owed by the block.
    efr_pkg::efr_in_t  line_q [$];
    efr_pkg::efr_out_t decoded_due [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;

    // Local copy of the receiver state.
    logic [7:0] rx_raw [FRAME_MAX];
    logic [7:0] rx_dec [FRAME_MAX];
    int         rx_count;
    logic [7:0] tmo_count;
    logic [7:0] tmo_reload;
    logic       rx_active;

    escaped_frame_receiver dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always #4 aclk = ~aclk;

    // Frame decoder -----------------------------------------------------------

    function automatic void drop_partial();
        for (int i = 0; i < FRAME_MAX; i++) begin
            rx_raw[i] = 8'h00;
        end
        rx_count = 0;
    endfunction

    // Raw positions count from 1; anything outside the buffer reads as zero.
    function automatic logic [7:0] raw_at(input int p);
        return (p >= 1 && p <= FRAME_MAX) ? rx_raw[p - 1] : 8'h00;
    endfunction

    // Remove escapes, work out the LRC verdict and queue the decoded bytes.
    function automatic void close_frame();
        int                j;
        int                y;
        int                last_pos;
        int                len;
        logic [7:0]        sum;
        logic              ok;
        efr_pkg::efr_out_t e;
        j = 2;
        y = 2;
        sum = 8'h00;
        ok = 1'b0;
        while (y <= rx_count && j < FRAME_MAX) begin
            if (raw_at(y) == efr_pkg::START_MARK) y++;
            if (y > rx_count) break;
            rx_dec[j] = raw_at(y);
            j++;
            y++;
        end
        last_pos = j - 1;
        if (last_pos >= 5) begin
            len = int'(rx_dec[5]);
            if (len + 6 <= last_pos) begin
                for (int k = 2; k < len + 6; k++) begin
                    sum = sum + rx_dec[k];
                end
                ok = (sum == rx_dec[len + 6]);
            end
        end
        for (int p = 2; p <= last_pos; p++) begin
            e.data_byte   = rx_dec[p];
            e.position    = 5'(p);
            e.last        = (p == last_pos);
            e.checksum_ok = (p == last_pos) && ok;
            decoded_due.push_back(e);
        end
        drop_partial();
    endfunction

    function automatic void decode_line_item(input efr_pkg::efr_in_t it);
        int run;
        // A tick counts the timeout down, twice while a frame is open.
        if (it.op == efr_pkg::OP_TICK) begin
            if (tmo_count != 0) tmo_count--;
            if (rx_active && tmo_count != 0) tmo_count--;
            if (tmo_count == 0) begin
                drop_partial();
                rx_active = 1'b0;
            end
            return;
        end
        rx_active = 1'b0;
        if (rx_count >= FRAME_MAX) drop_partial();
        rx_count++;
        rx_raw[rx_count - 1] = it.rx_byte;
        if (rx_raw[0] == efr_pkg::START_MARK) begin
            tmo_count = tmo_reload;
            rx_active = 1'b1;
            if (rx_count >= FRAME_MAX) drop_partial();
            // The end mark only counts after an even run of escape bytes.
            if (rx_count >= 2 && raw_at(rx_count) == efr_pkg::END_MARK) begin
                run = 0;
                for (int p = rx_count - 1; p > 0; p--) begin
                    if (raw_at(p) == efr_pkg::START_MARK) run++;
                    else break;
                end
                if (run % 2 == 0) begin
                    rx_active = 1'b0;
                    close_frame();
                    return;
                end
            end
        end else begin
            drop_partial();
        end
        if (rx_count >= FRAME_MAX) drop_partial();
    endfunction

    function automatic void check_decoded(input efr_pkg::efr_out_t got);
        efr_pkg::efr_out_t want;
        if (decoded_due.size() == 0) begin
            $error("unexpected item: data_byte %02h position %0d", got.data_byte,
                   got.position);
            fail_count++;
            return;
        end
        want = decoded_due.pop_front();
        if (got.data_byte !== want.data_byte) begin
            $error("data_byte: expected %02h, actual %02h", want.data_byte, got.data_byte);
            fail_count++;
        end
        if (got.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, got.position);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            fail_count++;
        end
        if (got.checksum_ok !== want.checksum_ok) begin
            $error("checksum_ok: expected %0b, actual %0b", want.checksum_ok,
                   got.checksum_ok);
            fail_count++;
        end
    endfunction

    // Driver and monitor ------------------------------------------------------

    // Present the next item once the current one is taken; idle at random.
    // The local decoder state starts over while reset is held.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            drop_partial();
            for (int i = 0; i < FRAME_MAX; i++) begin
                rx_dec[i] = 8'h00;
            end
            tmo_count = 8'h00;
            rx_active = 1'b0;
        end else begin
            if (s_valid && s_ready) decode_line_item(s_data);
            if (!s_valid || s_ready) begin
                if (line_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= line_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Accept decoded bytes with random stalls and check each one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
            if (m_valid && m_ready) check_decoded(m_data);
        end
    end

    // Stimulus ----------------------------------------------------------------

    function automatic void queue_byte(input logic [7:0] b);
        efr_pkg::efr_in_t it;
        it.op = efr_pkg::OP_BYTE;
        it.rx_byte = b;
        line_q.push_back(it);
    endfunction

    // The byte field is random on ticks too, since the block ignores it there.
    function automatic void queue_tick();
        efr_pkg::efr_in_t it;
        it.op = efr_pkg::OP_TICK;
        it.rx_byte = 8'($urandom_range(0, 255));
        line_q.push_back(it);
    endfunction

    // Build a stuffed frame with decoded positions 2 to last_pos plus the end mark,
    // length byte lrc_len and its LRC in place, optionally cut short, with ticks mixed in.
    function automatic void queue_frame(input int lrc_len, input int last_pos,
                                        input bit bad_sum, input int tick_pct,
                                        input int cut);
        logic [7:0] raw [$];
        logic [7:0] v;
        logic [7:0] sum;
        int         left;
        sum = 8'h00;
        left = cut;
        raw.push_back(efr_pkg::START_MARK);
        for (int k = 2; k <= last_pos; k++) begin
            if (k == 5) v = 8'(lrc_len);
            else if (k == lrc_len + 6) v = bad_sum ? sum + 8'd1 : sum;
            else if ($urandom_range(0, 15) == 0)
                v = $urandom_range(0, 1) ? efr_pkg::START_MARK : efr_pkg::END_MARK;
            else v = 8'($urandom_range(0, 255));
            if (k < lrc_len + 6) sum = sum + v;
            if (v == efr_pkg::START_MARK || v == efr_pkg::END_MARK ||
                $urandom_range(0, 9) == 0)
                raw.push_back(efr_pkg::START_MARK);
            raw.push_back(v);
        end
        raw.push_back(efr_pkg::END_MARK);
        while (left > 0 && raw.size() > 1) begin
            void'(raw.pop_back());
            left--;
        end
        foreach (raw[i]) begin
            if (i != 0 && $urandom_range(0, 99) < tick_pct) queue_tick();
            queue_byte(raw[i]);
        end
    endfunction

    // Eighteen bytes after the start mark; the last one is often the end mark.
    function automatic void queue_overlong();
        queue_byte(efr_pkg::START_MARK);
        repeat (17) queue_byte(8'($urandom_range(0, 126)));
        queue_byte($urandom_range(0, 1) ? efr_pkg::END_MARK
                                        : 8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_random(input int n_items);
        int goal;
        int pick;
        int ln;
        goal = line_q.size() + n_items;
        while (line_q.size() < goal) begin
            pick = $urandom_range(0, 99);
            ln = $urandom_range(0, 6);
            if (pick < 55) begin
                queue_frame(ln, ln + 6, $urandom_range(0, 4) == 0, 10, 0);
            end else if (pick < 62) begin
                // Long frames, which escapes may push past the size limit.
                ln = $urandom_range(7, 11);
                queue_frame(ln, ln + 6, 1'b0, 5, 0);
            end else if (pick < 68) begin
                // Length byte, where present, points past the end of the frame.
                queue_frame($urandom_range(12, 255), $urandom_range(2, 12), 1'b0, 5, 0);
            end else if (pick < 76) begin
                queue_frame(ln, ln + 6, 1'b0, 10, $urandom_range(1, ln + 8));
            end else if (pick < 82) begin
                queue_overlong();
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 30)) queue_tick();
            end else begin
                repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
            end
        end
    endfunction

    task automatic write_reload(input logic [7:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        tmo_reload = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every item is sent and every decoded byte has come back.
    task automatic drain();
        do @(posedge aclk);
        while (line_q.size() != 0 || s_valid || decoded_due.size() != 0);
        repeat (12) @(posedge aclk);
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'h00;
        tmo_reload  = efr_pkg::RELOAD_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Bad start bytes and a lone tick.
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_tick();
        // Smallest frame: an escaped end mark is the only decoded byte.
        queue_byte(efr_pkg::START_MARK);
        queue_byte(efr_pkg::START_MARK);
        queue_byte(efr_pkg::END_MARK);
        // Zero length field with a matching LRC and extreme byte values.
        queue_byte(efr_pkg::START_MARK);
        queue_byte(8'hFF);
        queue_byte(8'h00);
        queue_byte(8'h01);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(efr_pkg::END_MARK);
        // Odd escape run before an end mark, then a real end mark.
        queue_byte(efr_pkg::START_MARK);
        queue_byte(efr_pkg::START_MARK);
        queue_byte(efr_pkg::START_MARK);
        queue_byte(efr_pkg::END_MARK);
        queue_byte(efr_pkg::END_MARK);
        queue_tick();
        queue_tick();
        queue_random(70);
        drain();

        // Longest timeout, sender mostly idle.
        write_reload(8'd255);
        send_idle_pct = 65;
        stall_pct = 0;
        queue_random(85);
        drain();

        // Timeout reload of one, receiver mostly stalled.
        write_reload(8'd1);
        send_idle_pct = 0;
        stall_pct = 65;
        queue_random(85);
        drain();

        // Zero reload: any tick inside a frame drops it.
        write_reload(8'd0);
        send_idle_pct = 25;
        stall_pct = 25;
        queue_random(85);
        drain();

        write_reload(8'($urandom_range(2, 12)));
        send_idle_pct = 0;
        stall_pct = 0;
        queue_random(85);
        drain();

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/efr_pkg.sv
rtl/efr_front.sv
rtl/efr_queue.sv
rtl/efr_back.sv
rtl/escaped_frame_receiver.sv
rtl/efr_checker.sv
bench/testbench.sv
